// ===== hw/rtl/sstq_pkg.sv =====
// ---------------------------------------------------------------------------
// sstq_pkg: shared types and constants of the sorted timer queue
// Command codes, field widths and default parameter values.
// ---------------------------------------------------------------------------
`default_nettype none
package sstq_pkg;
  localparam int NUM_TIMERS_DEF = 32;
  localparam int TIME_BITS_DEF  = 32;
  localparam int ID_W    = 5;
  localparam int FIELD_W = 32;
  localparam int MPT_W   = 10;
  localparam int US_W    = 52;
  localparam logic [MPT_W-1:0] MPT_RESET = 10'd10;
  // microseconds per millisecond and width of msec_per_tick * 1000
  localparam int US_PER_MS = 1000;
  localparam int FACT_W    = 20;

  typedef enum logic [1:0] {
    CMD_MODIFY = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;
endpackage
`default_nettype wire

// ===== hw/rtl/sstq_if.sv =====
// ---------------------------------------------------------------------------
// sstq_in_if / sstq_out_if: valid/ready channels of the timer queue
// One word moves when valid and ready are both high.
// ---------------------------------------------------------------------------
`default_nettype none
interface sstq_in_if
  import sstq_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [ID_W-1:0]    timer_id;
  logic [FIELD_W-1:0] expires;
  logic [FIELD_W-1:0] now_ticks;
  modport source (output valid, command, timer_id, expires, now_ticks, input ready);
  modport sink   (input valid, command, timer_id, expires, now_ticks, output ready);
endinterface

interface sstq_out_if
  import sstq_pkg::*;
();
  logic            valid;
  logic            ready;
  logic            kind;
  logic [ID_W-1:0] fired_id;
  logic            was_active;
  logic            is_pending;
  logic            program_valid;
  logic [US_W-1:0] program_us;
  logic            last;
  modport source (output valid, kind, fired_id, was_active, is_pending, program_valid,
                  program_us, last, input ready);
  modport sink   (input valid, kind, fired_id, was_active, is_pending, program_valid,
                  program_us, last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sstq_ram.sv =====
// ---------------------------------------------------------------------------
// sstq_ram: generic single-port-write, single-read RAM
// Registered read.
// ---------------------------------------------------------------------------
`default_nettype none
module sstq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/sorted_software_timer_queue.sv =====
// ---------------------------------------------------------------------------
// sorted_software_timer_queue: timer list ordered by expiry tick
// Linked list of timer slots in RAM; modify, delete, query and tick.
// ---------------------------------------------------------------------------
//  channel | dir | words
//  in_     | in  | command, timer_id, expires, now_ticks
//  out_    | out | kind, fired_id, was_active, is_pending, program_valid,
//          |     | program_us, last
//  cfg_    | in  | msec_per_tick write
// One command at a time. The query result word is registered at acceptance.
// The list walks read one link per cycle from the expiry and link RAMs; the
// delay multiply is one registered 32x20 product.
// Reset is synchronous; the list is empty right after, no clearing pass.
// A stalled result word holds the engine until taken.
`default_nettype none
module sorted_software_timer_queue
  import sstq_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [MPT_W-1:0] cfg_wdata,
  sstq_in_if.sink               in_ch,
  sstq_out_if.source            out_ch
);
  localparam int AW = $clog2(NUM_TIMERS);
  localparam int CW = $clog2(NUM_TIMERS + 1);
  localparam int TW = (TIME_BITS < FIELD_W) ? TIME_BITS : FIELD_W;
  localparam int PW = TW + FACT_W;

  typedef enum logic [13:0] {
    S_IDLE   = 14'h0001,
    S_UL0    = 14'h0002, // read link of id
    S_UL1    = 14'h0004,
    S_ULWALK = 14'h0008, // walk for predecessor
    S_INS    = 14'h0010, // start insert walk
    S_INSCHK = 14'h0020,
    S_LINK   = 14'h0040,
    S_LINK2  = 14'h0080,
    S_TKRD   = 14'h0100, // read head expiry
    S_TKCHK  = 14'h0200,
    S_PGRD   = 14'h0400, // read head expiry and link
    S_PGCALC = 14'h0800,
    S_PGMUL  = 14'h1000,
    S_FIN    = 14'h2000
  } state_t;

  state_t state_r;
  logic [FACT_W-1:0] fact_r;
  logic [NUM_TIMERS-1:0] used_r, prog_r;
  logic [AW-1:0] head_r;
  logic [CW-1:0] cnt_r, walk_r;
  logic [TW-1:0] now_r;
  cmd_t          cmd_r;
  logic [AW-1:0] id_r, cur_r, prev_r, nid_r;
  logic          has_prev_r, was_r, pv_r, due_r, clr_r;
  logic [TW-1:0] exp_r;
  logic [TW-1:0] diff_r;
  logic [PW-1:0] prod_r;

  // output word registers
  logic            ov_r, okind_r, owas_r, opend_r, opv_r, olast_r;
  logic [ID_W-1:0] ofid_r;
  logic [US_W-1:0] ous_r;

  // rams
  logic          e_we, n_we;
  logic [AW-1:0] n_wa, n_wd, rd_a, n_rd, nxt_rd;
  logic [TW-1:0] e_rd;

  sstq_ram #(.WIDTH(TW), .DEPTH(NUM_TIMERS)) u_exp (
    .clk(clk), .we(e_we), .waddr(id_r), .wdata(exp_r), .raddr(rd_a), .rdata(e_rd));
  sstq_ram #(.WIDTH(AW), .DEPTH(NUM_TIMERS)) u_nxt (
    .clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(rd_a), .rdata(n_rd));

  function automatic logic [AW-1:0] fix(input logic [AW-1:0] x);
    return (32'(x) < NUM_TIMERS) ? x : '0;
  endfunction

  logic          in_fire, out_fire, out_free, ok_in, listed_in;
  logic          ins_stop, pop_now, ov_set;
  logic [CW-1:0] walk_inc;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_fire  = ov_r && out_ch.ready;
  assign out_free  = !ov_r || out_ch.ready;
  assign ok_in     = 32'(in_ch.timer_id) < NUM_TIMERS;
  assign listed_in = ok_in && used_r[AW'(in_ch.timer_id)];
  assign nxt_rd    = fix(n_rd);
  assign walk_inc  = walk_r + 1'b1;
  assign ins_stop  = (exp_r <= e_rd) || (walk_inc == cnt_r);
  assign pop_now   = (cnt_r != '0) && (e_rd <= now_r);

  assign in_ch.ready       = (state_r == S_IDLE) && !ov_r;
  assign out_ch.valid      = ov_r;
  assign out_ch.kind       = okind_r;
  assign out_ch.fired_id   = ofid_r;
  assign out_ch.was_active = owas_r;
  assign out_ch.is_pending = opend_r;
  assign out_ch.program_valid = opv_r;
  assign out_ch.program_us = ous_r;
  assign out_ch.last       = olast_r;

  // ram address and write control
  always_comb begin
    e_we = 1'b0;
    n_we = 1'b0; n_wa = id_r; n_wd = cur_r;
    rd_a = head_r;
    unique case (state_r)
      S_UL0:    rd_a = id_r;
      S_ULWALK: begin
        // predecessor found: bridge it over id, else follow its link
        if (n_rd == id_r) begin
          n_we = 1'b1; n_wa = cur_r; n_wd = nid_r;
        end else begin
          rd_a = nxt_rd;
        end
      end
      S_INS:    e_we = 1'b1;
      S_INSCHK: begin
        if (!ins_stop) rd_a = nxt_rd;
      end
      S_LINK:   n_we = 1'b1;
      S_LINK2:  begin
        n_we = 1'b1; n_wa = prev_r; n_wd = id_r;
      end
      default: ;
    endcase
  end

  // result word valid
  assign ov_set = (state_r == S_IDLE && in_fire && cmd_t'(in_ch.command) == CMD_QUERY) ||
                  (state_r == S_TKCHK && pop_now && out_free) ||
                  (state_r == S_FIN && out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (ov_set) ov_r <= 1'b1;
    else if (out_fire) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; fact_r <= FACT_W'(MPT_RESET) * FACT_W'(US_PER_MS);
      used_r <= '0; prog_r <= '0; head_r <= '0; cnt_r <= '0; now_r <= '0;
    end else begin
      if (cfg_we) fact_r <= FACT_W'(cfg_wdata) * FACT_W'(US_PER_MS);
      unique case (state_r)
        S_IDLE: if (in_fire) begin
          cmd_r <= cmd_t'(in_ch.command);
          id_r  <= ok_in ? AW'(in_ch.timer_id) : '0;
          exp_r <= TW'(in_ch.expires);
          was_r <= listed_in;
          unique case (cmd_t'(in_ch.command))
            CMD_QUERY: begin
              okind_r <= 1'b0; ofid_r <= '0; owas_r <= 1'b0; opv_r <= 1'b0;
              ous_r <= '0; olast_r <= 1'b1; opend_r <= listed_in;
            end
            CMD_TICK: begin now_r <= TW'(in_ch.now_ticks); state_r <= S_TKRD; end
            CMD_MODIFY: begin
              if (listed_in) state_r <= S_UL0;
              else if (ok_in) state_r <= S_INS;
              else state_r <= S_PGRD;
            end
            CMD_DELETE: state_r <= listed_in ? S_UL0 : S_PGRD;
          endcase
        end
        // unlink id_r
        S_UL0: state_r <= S_UL1;
        S_UL1: begin
          nid_r <= n_rd;
          used_r[id_r] <= 1'b0;
          cnt_r <= cnt_r - 1'b1;
          if (head_r == id_r) begin
            head_r <= nxt_rd;
            state_r <= (cmd_r == CMD_MODIFY) ? S_INS : S_PGRD;
          end else begin
            cur_r <= head_r; state_r <= S_ULWALK;
          end
        end
        S_ULWALK: begin
          if (n_rd == id_r) state_r <= (cmd_r == CMD_MODIFY) ? S_INS : S_PGRD;
          else cur_r <= nxt_rd;
        end
        // insert id_r, equal expiry goes ahead
        S_INS: begin
          prog_r[id_r] <= 1'b0;
          cur_r <= head_r; walk_r <= '0; has_prev_r <= 1'b0;
          state_r <= (cnt_r == '0) ? S_LINK : S_INSCHK;
        end
        S_INSCHK: begin
          if (exp_r <= e_rd) begin
            state_r <= S_LINK;
          end else begin
            prev_r <= cur_r; has_prev_r <= 1'b1;
            // past the tail the link of id is never followed
            if (walk_inc == cnt_r) begin
              state_r <= S_LINK;
            end else begin
              cur_r <= nxt_rd; walk_r <= walk_inc;
            end
          end
        end
        S_LINK: begin
          used_r[id_r] <= 1'b1; cnt_r <= cnt_r + 1'b1;
          if (has_prev_r) begin
            state_r <= S_LINK2;
          end else begin
            head_r <= id_r; state_r <= S_PGRD;
          end
        end
        S_LINK2: state_r <= S_PGRD;
        // tick pops
        S_TKRD: state_r <= S_TKCHK;
        S_TKCHK: begin
          if (!pop_now) begin
            state_r <= S_PGRD;
          end else if (out_free) begin
            okind_r <= 1'b1; ofid_r <= ID_W'(head_r); owas_r <= 1'b0; opend_r <= 1'b0;
            opv_r <= 1'b0; ous_r <= '0; olast_r <= 1'b0;
            used_r[head_r] <= 1'b0; cnt_r <= cnt_r - 1'b1; head_r <= nxt_rd;
            state_r <= S_TKRD;
          end
        end
        // program request for the head
        S_PGRD: state_r <= S_PGCALC;
        S_PGCALC: begin
          nid_r <= nxt_rd;
          clr_r <= cnt_r >= CW'(2);
          if (cnt_r == '0 || prog_r[head_r]) begin
            pv_r <= 1'b0; state_r <= S_FIN;
          end else begin
            pv_r <= 1'b1; prog_r[head_r] <= 1'b1;
            due_r <= e_rd <= now_r;
            diff_r <= e_rd - now_r;
            state_r <= S_PGMUL;
          end
        end
        S_PGMUL: begin
          // product fits 52 bits for time of up to 32 bits
          prod_r <= PW'(diff_r) * PW'(fact_r);
          if (clr_r) prog_r[nid_r] <= 1'b0;
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            okind_r <= 1'b0; ofid_r <= '0; opend_r <= 1'b0; olast_r <= 1'b1;
            owas_r <= (cmd_r == CMD_TICK) ? 1'b0 : was_r;
            opv_r <= pv_r;
            ous_r <= (pv_r && !due_r) ? US_W'(prod_r) : '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== bench/sorted_software_timer_queue_tb.sv =====
// ---------------------------------------------------------------------------
// sorted_software_timer_queue_tb: testbench of the sorted timer queue
// Drives modify, delete, query and tick commands with random idling on both
// channels, predicts every result word from a local model of the list and
// compares each accepted word field by field, in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module sorted_software_timer_queue_tb
  import sstq_pkg::*;
();

  localparam int NT = NUM_TIMERS_DEF;
  localparam logic [US_W-1:0] US_ALL = {US_W{1'b1}};
  localparam int CYCLE_LIMIT = 900000;

  typedef struct packed {
    logic            kind;
    logic [ID_W-1:0] fired_id;
    logic            was_active;
    logic            is_pending;
    logic            program_valid;
    logic [US_W-1:0] program_us;
    logic            last;
  } timer_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [MPT_W-1:0] cfg_wdata = '0;

  sstq_in_if  in_ch();
  sstq_out_if out_ch();

  sorted_software_timer_queue u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #5 clk = ~clk;

  // model state of the timer list
  logic [MPT_W-1:0] mdl_mpt;
  logic             mdl_used [NT];
  logic [31:0]      mdl_exp  [NT];
  logic             mdl_prog [NT];
  int unsigned      mdl_next [NT];
  int unsigned      mdl_head;
  int unsigned      mdl_count;
  logic [31:0]      mdl_now;

  timer_word_t expected_words[$];
  int  mismatches = 0;
  int  cycles = 0;
  bit  no_idle = 0;

  // unlink a listed slot
  task automatic list_remove(int unsigned id);
    int unsigned p;
    if (!mdl_used[id]) return;
    if (mdl_head == id) mdl_head = mdl_next[id];
    else begin
      p = mdl_head;
      for (int i = 0; i + 1 < mdl_count; i++) begin
        if (mdl_next[p] == id) begin
          mdl_next[p] = mdl_next[id];
          break;
        end
        p = mdl_next[p];
      end
    end
    mdl_used[id] = 1'b0;
    if (mdl_count > 0) mdl_count--;
  endtask

  // sorted insert, equal expiry goes first
  task automatic list_insert(int unsigned id);
    int unsigned cur, prev;
    bit has_prev;
    cur = mdl_head; prev = 0; has_prev = 0;
    for (int i = 0; i < mdl_count; i++) begin
      if (mdl_exp[id] <= mdl_exp[cur]) break;
      prev = cur; has_prev = 1;
      cur = mdl_next[cur];
    end
    mdl_next[id] = cur;
    if (has_prev) mdl_next[prev] = id;
    else mdl_head = id;
    mdl_used[id] = 1'b1;
    mdl_count++;
  endtask

  // program request for an unprogrammed head
  task automatic head_program(output logic pv, output logic [US_W-1:0] us);
    logic [63:0] d, f;
    int unsigned h;
    h = mdl_head; pv = 0; us = '0;
    if (mdl_count == 0 || mdl_prog[h]) return;
    pv = 1;
    if (mdl_exp[h] > mdl_now) begin
      d = 64'(mdl_exp[h] - mdl_now);
      f = 64'(mdl_mpt) * 64'd1000;
      if (f == 0) us = '0;
      else if (d > 64'(US_ALL) / f) us = US_ALL;
      else us = US_W'(d * f);
    end
    mdl_prog[h] = 1'b1;
    if (mdl_count >= 2) mdl_prog[mdl_next[h]] = 1'b0;
  endtask

  task automatic push_word(logic k, logic [ID_W-1:0] fid, logic was, logic pend,
                           logic pv, logic [US_W-1:0] us, logic lst);
    timer_word_t w;
    w = '{k, fid, was, pend, pv, us, lst};
    expected_words.push_back(w);
  endtask

  task automatic predict_timer_cmd(cmd_t cmd, int unsigned id, logic [31:0] ex,
                                   logic [31:0] nw);
    logic pv, was;
    logic [US_W-1:0] us;
    int unsigned h;
    case (cmd)
      CMD_MODIFY: begin
        was = mdl_used[id];
        list_remove(id);
        mdl_exp[id] = ex;
        mdl_prog[id] = 1'b0;
        list_insert(id);
        head_program(pv, us);
        push_word(0, 0, was, 0, pv, us, 1);
      end
      CMD_DELETE: begin
        was = mdl_used[id];
        list_remove(id);
        head_program(pv, us);
        push_word(0, 0, was, 0, pv, us, 1);
      end
      CMD_QUERY: push_word(0, 0, 0, mdl_used[id], 0, '0, 1);
      default: begin
        mdl_now = nw;
        while (mdl_count > 0 && mdl_exp[mdl_head] <= mdl_now) begin
          h = mdl_head;
          push_word(1, ID_W'(h), 0, 0, 0, '0, 0);
          list_remove(h);
        end
        head_program(pv, us);
        push_word(0, 0, 0, 0, pv, us, 1);
      end
    endcase
  endtask

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 14);
  endfunction

  // send one command word, predict at acceptance
  task automatic send_cmd(cmd_t cmd, logic [ID_W-1:0] id, logic [31:0] ex,
                          logic [31:0] nw);
    while (idle_now()) @(posedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.timer_id  <= id;
    in_ch.expires   <= ex;
    in_ch.now_ticks <= nw;
    do @(posedge clk); while (!in_ch.ready);
    predict_timer_cmd(cmd, id, ex, nw);
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for all results, then a quiet period before a register write
  task automatic drain_results();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_mpt(logic [MPT_W-1:0] v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    mdl_mpt = v;
    cfg_we <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    timer_word_t got, exp_w;
    if (rst_n) out_ch.ready <= !idle_now();
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.kind, out_ch.fired_id, out_ch.was_active, out_ch.is_pending,
              out_ch.program_valid, out_ch.program_us, out_ch.last};
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
        mismatches++;
      end else begin
        exp_w = expected_words.pop_front();
        if (got.kind !== exp_w.kind || got.fired_id !== exp_w.fired_id ||
            got.was_active !== exp_w.was_active ||
            got.is_pending !== exp_w.is_pending ||
            got.program_valid !== exp_w.program_valid ||
            got.program_us !== exp_w.program_us || got.last !== exp_w.last) begin
          $display("%0t: mismatch, expected %h, actual %h", $time, exp_w, got);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_directed();
    send_cmd(CMD_QUERY, 5'd0, '0, '0);
    send_cmd(CMD_DELETE, 5'd31, '0, '0);
    send_cmd(CMD_MODIFY, 5'd3, 32'd100, '0);
    send_cmd(CMD_MODIFY, 5'd7, 32'd100, '0);       // equal expiry goes ahead
    send_cmd(CMD_MODIFY, 5'd31, 32'hFFFF_FFFF, '0); // largest expiry
    send_cmd(CMD_MODIFY, 5'd0, 32'd0, '0);          // already due
    send_cmd(CMD_QUERY, 5'd7, '0, '0);
    send_cmd(CMD_MODIFY, 5'd7, 32'd50, '0);         // reschedule
    send_cmd(CMD_DELETE, 5'd0, '0, '0);             // delete head
    send_cmd(CMD_DELETE, 5'd0, '0, '0);             // not present
    send_cmd(CMD_TICK, '0, '0, 32'd100);
    send_cmd(CMD_QUERY, 5'd31, '0, '0);
    send_cmd(CMD_TICK, '0, '0, 32'hFFFF_FFFF);       // fire all
    send_cmd(CMD_TICK, '0, '0, 32'd0);               // empty list
  endtask

  task automatic test_config_extremes();
    write_mpt(10'd1);
    send_cmd(CMD_MODIFY, 5'd1, 32'd5, '0);
    send_cmd(CMD_MODIFY, 5'd2, 32'hFFFF_FFFF, '0);
    send_cmd(CMD_DELETE, 5'd1, '0, '0);
    write_mpt(10'd1000);
    send_cmd(CMD_MODIFY, 5'd4, 32'h0010_0000, '0);
    send_cmd(CMD_DELETE, 5'd4, '0, '0);
    write_mpt(10'h3FF);
    send_cmd(CMD_MODIFY, 5'd9, 32'h7FFF_FFFF, '0);
    send_cmd(CMD_TICK, '0, '0, 32'hFFFF_FFFF);
  endtask

  task automatic test_random(int n);
    int r;
    logic [31:0] base;
    for (int i = 0; i < n; i++) begin
      no_idle = (i >= n / 2 && i < n / 2 + 40);
      base = mdl_now;
      r = $urandom_range(99);
      if (r < 45)
        send_cmd(CMD_MODIFY, ID_W'($urandom),
                 ($urandom_range(9) == 0) ? $urandom : base + $urandom_range(200), '0);
      else if (r < 60) send_cmd(CMD_DELETE, ID_W'($urandom), $urandom, $urandom);
      else if (r < 75) send_cmd(CMD_QUERY, ID_W'($urandom), $urandom, $urandom);
      else
        send_cmd(CMD_TICK, ID_W'($urandom), $urandom,
                 ($urandom_range(19) == 0) ? $urandom : base + $urandom_range(120));
    end
    no_idle = 0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = CMD_MODIFY;
    in_ch.timer_id = '0;
    in_ch.expires = '0;
    in_ch.now_ticks = '0;
    out_ch.ready = 1'b0;
    mdl_mpt = MPT_RESET;
    for (int i = 0; i < NT; i++) begin
      mdl_used[i] = 0; mdl_exp[i] = '0; mdl_prog[i] = 0; mdl_next[i] = 0;
    end
    mdl_head = 0; mdl_count = 0; mdl_now = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    write_mpt(10'd10);
    test_random(90);
    write_mpt(10'd357);
    test_random(97);
    drain_results();
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire
